>>> rtl/core/lpt_pkg.sv
package lpt_pkg;

   localparam int PROC_W     = 3;
   localparam int PAGE_W     = 4;
   localparam int OFF_W      = 6;
   localparam int LADDR_W    = PAGE_W + OFF_W;
   localparam int FRAME_W    = 4;
   localparam int PADDR_W    = FRAME_W + OFF_W;
   localparam int TIME_W     = 5;
   localparam int MAX_PROCS  = 8;
   localparam int MAX_FRAMES = 16;
   localparam int ENTRY_AW   = PROC_W + PAGE_W;
   localparam int NUM_ENTRIES = MAX_PROCS * (1 << PAGE_W);
   localparam int FRAMES_W   = 5;
   localparam int PROCS_W    = 4;

   localparam logic [TIME_W-1:0]   TIME_LAST     = 5'd31;
   localparam logic [FRAMES_W-1:0] FRAMES_RESET  = 5'd4;
   localparam logic [PROCS_W-1:0]  PROCS_RESET   = 4'd2;

   localparam int REQ_W      = 16;
   localparam int RSP_W      = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_USE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROCS_IN_USE  = 1'd1;

   // controller to datapath
   typedef struct packed {
      logic accept;     // latch request fields
      logic rd_entry;   // read page entry of the request
      logic check;      // capture hit and resident frame
      logic scan_clr;   // restart frame scan
      logic scan_inc;   // advance free-frame scan
      logic take_free;  // use scanned frame as the free one
      logic lru_start;  // begin victim search
      logic lru_issue;  // read timestamp of scanned frame
      logic write;      // commit update and load result
      logic reject;     // load all-zero result
   } lpt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic oor;        // process not in use
      logic rd_hit;     // page entry present
      logic fo_free;    // scanned frame is free
      logic scan_last;  // scanned frame is the last one in use
      logic rsp_free;   // result register can take a new item
   } lpt_status_type;

endpackage

>>> rtl/core/lpt_ctrl.sv
module lpt_ctrl
   import lpt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  lpt_status_type status,
   output lpt_cmd_type    cmd
);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_READ     = 8'b0000_0010,
      S_CHECK    = 8'b0000_0100,
      S_FREE     = 8'b0000_1000,
      S_LRU      = 8'b0001_0000,
      S_LRU_TAIL = 8'b0010_0000,
      S_WRITE    = 8'b0100_0000,
      S_REJECT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            if (status.oor) begin
               state_in = S_REJECT;
            end else begin
               cmd.rd_entry = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (status.rd_hit) begin
               state_in = S_WRITE;
            end else begin
               cmd.scan_clr = 1'b1;
               state_in     = S_FREE;
            end
         end
         S_FREE: begin
            if (status.fo_free) begin
               cmd.take_free = 1'b1;
               state_in      = S_WRITE;
            end else if (status.scan_last) begin
               cmd.lru_start = 1'b1;
               state_in      = S_LRU;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         S_LRU: begin
            cmd.lru_issue = 1'b1;
            if (status.scan_last) state_in = S_LRU_TAIL;
         end
         S_LRU_TAIL: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (status.rsp_free) begin
               cmd.write = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_REJECT: begin
            if (status.rsp_free) begin
               cmd.reject = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> state_ff == S_IDLE)
      else $error("item accepted outside idle");

   a_commit_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.write || cmd.reject) |=> state_ff == S_IDLE)
      else $error("controller did not return to idle after commit");

   a_lru_reaches_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LRU_TAIL |=> state_ff == S_WRITE)
      else $error("victim search did not end in write");

endmodule

>>> rtl/core/lpt_datapath.sv
module lpt_datapath
   import lpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  lpt_cmd_type           cmd,
   output lpt_status_type        status,
   input  logic [REQ_W-1:0]      req_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata
);

   // configuration
   logic [FRAMES_W-1:0] frames_ff;
   logic [PROCS_W-1:0]  procs_ff;
   logic [FRAMES_W-1:0] nf;
   logic [PROCS_W-1:0]  np;

   // request
   logic [PROC_W-1:0]   proc_ff;
   logic [PAGE_W-1:0]   page_ff;
   logic [OFF_W-1:0]    off_ff;
   logic [ENTRY_AW-1:0] idx;

   // page entries: frame and timestamp in memory, flags in flops
   logic [FRAME_W+TIME_W-1:0] ent_mem [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0]    present_ff;
   logic [NUM_ENTRIES-1:0]    present_in;
   logic [NUM_ENTRIES-1:0]    tvld_ff;
   logic [NUM_ENTRIES-1:0]    tvld_in;
   logic [ENTRY_AW-1:0]       rd_addr;
   logic [FRAME_W+TIME_W-1:0] rd_data_ff;
   logic                      rd_present_ff;
   logic                      rd_tvld_ff;
   logic [TIME_W-1:0]         rd_ts;

   // frame owners
   logic [MAX_FRAMES-1:0] fo_valid_ff;
   logic [PROC_W-1:0]     fo_proc_ff [MAX_FRAMES];
   logic [PAGE_W-1:0]     fo_page_ff [MAX_FRAMES];

   // scan and victim search
   logic [FRAME_W-1:0] scan_ff;
   logic               pipe_vld_ff;
   logic [FRAME_W-1:0] pipe_frame_ff;
   logic [PROC_W-1:0]  pipe_proc_ff;
   logic [PAGE_W-1:0]  pipe_page_ff;
   logic [TIME_W:0]    best_t_ff;
   logic [PROC_W-1:0]  vic_proc_ff;
   logic [PAGE_W-1:0]  vic_page_ff;
   logic [ENTRY_AW-1:0] vic_idx;

   logic               hit_ff;
   logic               evict_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic [TIME_W-1:0]  time_ff;
   logic               wrap;
   logic [TIME_W-1:0]  time_val;

   logic               rsp_tvalid_ff;
   logic [RSP_W-1:0]   rsp_data_ff;
   logic [RSP_W-1:0]   rsp_data_in;

   assign nf = (frames_ff == '0) ? FRAMES_W'(1) :
               (frames_ff > FRAMES_W'(MAX_FRAMES)) ? FRAMES_W'(MAX_FRAMES) : frames_ff;
   assign np = (procs_ff == '0) ? PROCS_W'(1) :
               (procs_ff > PROCS_W'(MAX_PROCS)) ? PROCS_W'(MAX_PROCS) : procs_ff;

   assign idx      = {proc_ff, page_ff};
   assign vic_idx  = {vic_proc_ff, vic_page_ff};
   assign rd_addr  = cmd.lru_issue ? {fo_proc_ff[scan_ff], fo_page_ff[scan_ff]} : idx;
   assign rd_ts    = rd_tvld_ff ? rd_data_ff[TIME_W-1:0] : '0;
   assign wrap     = (time_ff == TIME_LAST);
   assign time_val = wrap ? TIME_W'(1) : time_ff;

   assign status.oor       = {1'b0, proc_ff} >= np;
   assign status.rd_hit    = rd_present_ff;
   assign status.fo_free   = !fo_valid_ff[scan_ff];
   assign status.scan_last = {1'b0, scan_ff} == (nf - FRAMES_W'(1));
   assign status.rsp_free  = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FRAMES_RESET;
         procs_ff  <= PROCS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAMES_IN_USE: frames_ff <= csr_wdata[FRAMES_W-1:0];
            CSR_PROCS_IN_USE:  procs_ff  <= csr_wdata[PROCS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         proc_ff <= req_tdata[PROC_W-1:0];
         page_ff <= req_tdata[PROC_W+OFF_W +: PAGE_W];
         off_ff  <= req_tdata[PROC_W +: OFF_W];
      end
   end

   // entry memory: one read port, one write port
   always_ff @(posedge clock) begin
      if (cmd.rd_entry || cmd.lru_issue) rd_data_ff <= ent_mem[rd_addr];
      if (cmd.write) ent_mem[idx] <= {frame_ff, time_val};
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_entry || cmd.lru_issue) begin
         rd_present_ff <= present_ff[rd_addr];
         rd_tvld_ff    <= tvld_ff[rd_addr];
      end
   end

   // entry flags; clear the victim, mark the current entry, drop all stamps on wrap
   always_comb begin
      present_in = present_ff;
      tvld_in    = tvld_ff;
      if (cmd.write) begin
         if (evict_ff) begin
            present_in[vic_idx] = 1'b0;
            tvld_in[vic_idx]    = 1'b0;
         end
         if (wrap) tvld_in = '0;
         present_in[idx] = 1'b1;
         tvld_in[idx]    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         tvld_ff    <= '0;
      end else begin
         present_ff <= present_in;
         tvld_ff    <= tvld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fo_valid_ff <= '0;
      end else if (cmd.write && !hit_ff) begin
         fo_valid_ff[frame_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write && !hit_ff) begin
         fo_proc_ff[frame_ff] <= proc_ff;
         fo_page_ff[frame_ff] <= page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) pipe_vld_ff <= 1'b0;
      else       pipe_vld_ff <= cmd.lru_issue;
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_clr || cmd.lru_start)             scan_ff <= '0;
      else if (cmd.scan_inc || cmd.lru_issue)        scan_ff <= scan_ff + FRAME_W'(1);
      if (cmd.lru_issue) begin
         pipe_frame_ff <= scan_ff;
         pipe_proc_ff  <= fo_proc_ff[scan_ff];
         pipe_page_ff  <= fo_page_ff[scan_ff];
      end
   end

   // victim search: keep the oldest stamp, first frame wins a tie
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         evict_ff <= 1'b0;
      end else if (cmd.lru_start) begin
         evict_ff <= 1'b1;
      end
      if (cmd.lru_start) begin
         best_t_ff <= '1;
      end else if (pipe_vld_ff && ({1'b0, rd_ts} < best_t_ff)) begin
         best_t_ff   <= {1'b0, rd_ts};
         vic_proc_ff <= pipe_proc_ff;
         vic_page_ff <= pipe_page_ff;
      end
      if (cmd.check) begin
         hit_ff   <= rd_present_ff;
         frame_ff <= rd_data_ff[FRAME_W+TIME_W-1:TIME_W];
      end else if (cmd.take_free) begin
         frame_ff <= scan_ff;
      end else if (pipe_vld_ff && ({1'b0, rd_ts} < best_t_ff)) begin
         frame_ff <= pipe_frame_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) time_ff <= '0;
      else if (cmd.write) time_ff <= wrap ? '0 : time_ff + TIME_W'(1);
   end

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[0]     = hit_ff;
      rsp_data_in[4:1]   = frame_ff;
      rsp_data_in[14:5]  = {frame_ff, off_ff};
      rsp_data_in[15]    = evict_ff;
      if (evict_ff) begin
         rsp_data_in[18:16] = vic_proc_ff;
         rsp_data_in[22:19] = vic_page_ff;
         rsp_data_in[27:23] = best_t_ff[TIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.write || cmd.reject) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write)       rsp_data_ff <= rsp_data_in;
      else if (cmd.reject) rsp_data_ff <= '0;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> !(hit_ff && evict_ff))
      else $error("hit with eviction");

   a_victim_present: assert property (@(posedge clock) disable iff (reset)
      (cmd.write && evict_ff) |-> present_ff[vic_idx])
      else $error("victim page not resident");

   a_victim_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.write && evict_ff) |-> ({1'b0, frame_ff} < nf))
      else $error("victim frame above frames in use");

   a_time_advance: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> (time_ff == $past(time_ff) + TIME_W'(1)) || (time_ff == '0))
      else $error("time did not advance");

endmodule

>>> rtl/core/lru_page_table_translate_core.sv
// LRU page translation core.
// req channel: one item per access (process, logical address). Bits 9..6 of
// the address pick the page, bits 5..0 pass through as the offset.
// rsp channel: exactly one item per request: hit flag, frame, physical
// address and, on a replacement, owner, page and timestamp of the victim.
// csr port: write frames_in_use (index 0) and procs_in_use (index 1) while idle.
// A hit goes through read, check and result load; an unused process goes
// straight to the all-zero result; a miss first scans for a free frame and,
// when none is free, searches every frame in use for the victim.
// The frame scan and the victim scan step one frame per cycle through the
// single read port of the page entry memory; one item is in flight at a time.
// The next item is accepted in the cycle after a result loads, so a new item
// is taken only once the last one has loaded its result.
// A timestamp wrap clears all stamps at once through per-entry flags.
// Reset: page tables empty, all frames free, time 0, frames_in_use 4,
// procs_in_use 2; no clearing pass is needed.
// When rsp_tready stays low the finished item waits in the output register;
// the next request is still accepted and worked on, and it holds before its
// own result load until the register frees.
module lru_page_table_translate_core
   import lpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // [2:0] process, [12:3] logical_address
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // [0] hit, [4:1] frame,
                                              // [14:5] physical_address, [15] evicted,
                                              // [18:16] evicted_process,
                                              // [22:19] evicted_page, [27:23] evicted_time
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   lpt_cmd_type    cmd;
   lpt_status_type status;

   // sequence lookup, free scan, victim scan and commit
   lpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // page tables, frame owners, time and result register
   lpt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> tb/lru_page_table_translate_core_test.sv
module lru_page_table_translate_core_test;
   import lpt_pkg::*;

   // One translation result, packed as it travels on rsp_tdata[27:0]
   typedef struct packed {
      logic [TIME_W-1:0]  ev_time;
      logic [PAGE_W-1:0]  ev_page;
      logic [PROC_W-1:0]  ev_proc;
      logic               evicted;
      logic [PADDR_W-1:0] paddr;
      logic [FRAME_W-1:0] frame;
      logic               hit;
   } xlate_result_type;

   localparam int QUIET_LIMIT = 2000;   // cycles with no item moving on either side
   localparam int HOLD_AT     = 400;    // result count that starts the long stall
   localparam int HOLD_LEN    = 300;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Pending accesses for the driver and translations still owed by the block
   logic [REQ_W-1:0] access_queue[$];
   xlate_result_type expected_xlates[$];

   int fail_count   = 0;
   int results_seen = 0;
   int quiet_cycles = 0;
   int send_gap     = 0;
   int recv_wait    = 0;
   int hold_left    = 0;
   bit idle_on      = 1'b1;

   // Shadow of the page tables, the frame owners, the LRU clock and the registers
   bit                 slot_present[NUM_ENTRIES];
   bit [FRAME_W-1:0]   slot_frame[NUM_ENTRIES];
   bit [TIME_W-1:0]    slot_stamp[NUM_ENTRIES];
   bit                 frame_busy[MAX_FRAMES];
   bit [PROC_W-1:0]    frame_proc[MAX_FRAMES];
   bit [PAGE_W-1:0]    frame_page[MAX_FRAMES];
   int                 lru_time = 0;
   logic [FRAMES_W-1:0] cfg_frames = FRAMES_RESET;
   logic [PROCS_W-1:0]  cfg_procs  = PROCS_RESET;

   lru_page_table_translate_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // A register value of zero acts as one, anything above the maximum as the maximum
   function automatic int bounded_count(input int value, input int max_value);
      return (value == 0) ? 1 : ((value > max_value) ? max_value : value);
   endfunction

   // Translate one access against the shadow state and advance it
   function automatic xlate_result_type translate_access(input logic [PROC_W-1:0] proc,
                                                         input logic [LADDR_W-1:0] laddr);
      xlate_result_type res;
      logic [PAGE_W-1:0] page;
      int np, nf, idx, fr, best, best_stamp, victim;
      bit found;
      res  = '0;
      page = laddr[LADDR_W-1:OFF_W];
      np   = bounded_count(cfg_procs, MAX_PROCS);
      nf   = bounded_count(cfg_frames, MAX_FRAMES);
      // unused process: all-zero result, nothing changes, clock holds
      if (proc >= np)
         return res;
      idx = proc * (1 << PAGE_W) + page;
      if (slot_present[idx]) begin
         res.hit = 1'b1;
         fr = slot_frame[idx];
         slot_stamp[idx] = TIME_W'(lru_time);
      end else begin
         // lowest free frame among those in use
         found = 1'b0;
         fr = 0;
         for (int f = 0; f < nf; f++) begin
            if (!found && !frame_busy[f]) begin
               fr = f;
               found = 1'b1;
            end
         end
         if (!found) begin
            // oldest stamp wins, ties go to the lowest frame
            best = 0;
            best_stamp = 256;
            for (int f = 0; f < nf; f++) begin
               victim = frame_proc[f] * (1 << PAGE_W) + frame_page[f];
               if (slot_stamp[victim] < best_stamp) begin
                  best_stamp = slot_stamp[victim];
                  best = f;
               end
            end
            victim = frame_proc[best] * (1 << PAGE_W) + frame_page[best];
            res.evicted = 1'b1;
            res.ev_proc = frame_proc[best];
            res.ev_page = frame_page[best];
            res.ev_time = TIME_W'(best_stamp);
            slot_present[victim] = 1'b0;
            slot_frame[victim]   = '0;
            slot_stamp[victim]   = '0;
            fr = best;
         end
         frame_busy[fr]    = 1'b1;
         frame_proc[fr]    = proc;
         frame_page[fr]    = page;
         slot_present[idx] = 1'b1;
         slot_frame[idx]   = FRAME_W'(fr);
         slot_stamp[idx]   = TIME_W'(lru_time);
      end
      res.frame = FRAME_W'(fr);
      res.paddr = {res.frame, laddr[OFF_W-1:0]};
      // wrap: clear every stamp of every process, the current entry gets one
      if (lru_time + 1 >= 32) begin
         for (int e = 0; e < NUM_ENTRIES; e++)
            slot_stamp[e] = '0;
         slot_stamp[idx] = TIME_W'(1);
         lru_time = 0;
      end else begin
         lru_time = lru_time + 1;
      end
      return res;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Write one register; the shadow copy follows right away since the block is idle
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == CSR_FRAMES_IN_USE)
         cfg_frames = value;
      else
         cfg_procs = value[PROCS_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Sample at the falling edge so all handshake updates of the rising edge have settled
   task automatic wait_drained;
      @(negedge clock);
      while (access_queue.size() != 0 || req_tvalid || expected_xlates.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Driver: hold the item until taken, predict it at acceptance, then draw a gap
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_xlates.push_back(translate_access(req_tdata[PROC_W-1:0],
                                                       req_tdata[PROC_W +: LADDR_W]));
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (access_queue.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= access_queue.pop_front();
               send_gap = idle_on ? $urandom_range(0, 4) : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each item against the oldest translation owed, drive ready
   always @(posedge clock) begin : result_monitor
      xlate_result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(xlate_result_type)-1:0];
            if (expected_xlates.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual %0h", $time, got);
               fail_count++;
            end else begin
               want = expected_xlates.pop_front();
               check_field("hit", want.hit, got.hit);
               check_field("frame", want.frame, got.frame);
               check_field("physical_address", want.paddr, got.paddr);
               check_field("evicted", want.evicted, got.evicted);
               check_field("evicted_process", want.ev_proc, got.ev_proc);
               check_field("evicted_page", want.ev_page, got.ev_page);
               check_field("evicted_time", want.ev_time, got.ev_time);
            end
            results_seen++;
            recv_wait = idle_on ? $urandom_range(0, 4) : 0;
            // long stall once, so the block fills up and backs up the request side
            if (results_seen == HOLD_AT)
               hold_left = HOLD_LEN;
         end else if (hold_left != 0) begin
            hold_left--;
         end else if (rsp_tvalid && recv_wait != 0) begin
            recv_wait--;
         end
         rsp_tready <= (hold_left == 0) && (recv_wait == 0);
      end
   end

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("[lru_page_table_translate_core] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // directed: address extremes, hits, fills, evictions and unused processes
      int dir_proc[20] = '{0, 0, 1, 1, 0, 0, 0, 0, 1, 7, 2, 3, 0, 1, 0, 0, 1, 0, 4, 0};
      int dir_addr[20] = '{'h000, 'h03F, 'h3FF, 'h3C0, 'h040, 'h080, 'h0C0, 'h000,
                           'h3FF, 'h3FF, 'h155, 'h2AA, 'h2AA, 'h155, 'h0C5, 'h3FF,
                           'h000, 'h201, 'h1AB, 'h3C1};
      // settings per random phase; zero and out-of-range values included,
      // procs value 19 also sets the bit above the register width
      int phase_frames[8] = '{16, 1, 0, 31, 8, 3, 17, 12};
      int phase_procs[8]  = '{8, 1, 0, 15, 3, 8, 19, 5};
      int phase_items[8]  = '{250, 100, 60, 200, 200, 200, 150, 170};
      int np;
      logic [PROC_W-1:0] proc;
      logic [PAGE_W-1:0] page;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      for (int i = 0; i < 20; i++)
         access_queue.push_back({3'b000, dir_addr[i][LADDR_W-1:0], dir_proc[i][PROC_W-1:0]});
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         write_csr(CSR_FRAMES_IN_USE, phase_frames[p][CSR_DATA_W-1:0]);
         write_csr(CSR_PROCS_IN_USE, phase_procs[p][CSR_DATA_W-1:0]);
         @(negedge clock);
         // one phase runs with no idling at all
         idle_on = (p != 3);
         np = bounded_count(cfg_procs, MAX_PROCS);
         for (int n = 0; n < phase_items[p]; n++) begin
            // mostly active processes and a small working set, some noise
            proc = PROC_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                       : $urandom_range(0, np - 1));
            page = PAGE_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(0, 4));
            access_queue.push_back({3'b000, page, 6'($urandom), proc});
         end
         wait_drained();
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("[lru_page_table_translate_core] OK");
      else
         $display("[lru_page_table_translate_core] ERROR");
      $finish;
   end

endmodule
